FILE: src/bed_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the bounded edit distance block.
// No dependencies.
package bed_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int CHAR_W      = 8;
	localparam int DIST_W      = 4;
	localparam int LEN_W       = 5;
	localparam int MAXD_W      = 3;
	localparam int CFG_W       = 64;
	localparam int IDX_W       = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_PAT_LO   = 2'd0,
		REG_PAT_HI   = 2'd1,
		REG_PAT_LEN  = 2'd2,
		REG_MAX_DIST = 2'd3
	} cfg_reg_t;

	// item moving down the cell row
	typedef struct packed {
		logic              vld;
		logic              eow;
		logic [CHAR_W-1:0] ch;
	} tok_t;

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

	// min(j, lim) for the reset value of cell j
	function automatic logic [DIST_W-1:0] init_val(input int j, input logic [DIST_W-1:0] lim);
		logic [LEN_W-1:0] jj;
		logic [DIST_W-1:0] r;
		jj = LEN_W'(j);
		if (jj > {1'b0, lim}) begin
			r = lim;
		end else begin
			r = jj[DIST_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: src/bed_head.sv
`timescale 1ns / 1ps
// Column-zero cell: counts word characters, saturating at the limit.
// Depends on bed_pkg.
module bed_head
	import bed_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              init,
	input  logic [DIST_W-1:0] lim,
	input  tok_t              in_tok,
	output tok_t              tok,
	output logic [DIST_W-1:0] cur,
	output logic [DIST_W-1:0] prev
);

	tok_t              tok_q;
	logic [DIST_W-1:0] cur_q;
	logic [DIST_W-1:0] prev_q;
	logic [DIST_W-1:0] inc;

	always_comb begin
		inc = cur_q + DIST_W'(1);
		if (inc > lim) begin
			inc = lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			cur_q  <= '0;
			prev_q <= '0;
		end else if (init) begin
			tok_q <= '0;
			cur_q <= '0;
		end else if (adv) begin
			tok_q <= in_tok;
			if (in_tok.vld) begin
				if (in_tok.eow) begin
					cur_q <= '0;
				end else begin
					prev_q <= cur_q;
					cur_q  <= inc;
				end
			end
		end
	end

	assign tok  = tok_q;
	assign cur  = cur_q;
	assign prev = prev_q;

endmodule

FILE: src/bed_cell.sv
`timescale 1ns / 1ps
// One DP cell for a pattern prefix; takes the left neighbor's new and old
// values from the neighbor's registers. Depends on bed_pkg.
module bed_cell
	import bed_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              init,
	input  logic [DIST_W-1:0] init_value,
	input  logic [DIST_W-1:0] lim,
	input  logic [CHAR_W-1:0] pat_ch,
	input  tok_t              left_tok,
	input  logic [DIST_W-1:0] left_cur,
	input  logic [DIST_W-1:0] left_prev,
	output tok_t              tok,
	output logic [DIST_W-1:0] cur,
	output logic [DIST_W-1:0] prev
);

	tok_t              tok_q;
	logic [DIST_W-1:0] cur_q;
	logic [DIST_W-1:0] prev_q;
	logic [DIST_W-1:0] m;
	logic [DIST_W-1:0] nxt;

	always_comb begin
		// left_prev is the diagonal, cur_q the cell above
		m = (cur_q < left_cur) ? cur_q : left_cur;
		if (left_prev < m) begin
			m = left_prev;
		end
		if (pat_ch == left_tok.ch) begin
			nxt = left_prev;
		end else begin
			nxt = m + DIST_W'(1);
		end
		if (nxt > lim) begin
			nxt = lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			cur_q  <= '0;
			prev_q <= '0;
		end else if (init) begin
			tok_q <= '0;
			cur_q <= init_value;
		end else if (adv) begin
			tok_q <= left_tok;
			if (left_tok.vld) begin
				if (left_tok.eow) begin
					cur_q <= init_value;
				end else begin
					prev_q <= cur_q;
					cur_q  <= nxt;
				end
			end
		end
	end

	assign tok  = tok_q;
	assign cur  = cur_q;
	assign prev = prev_q;

endmodule

FILE: src/bounded_edit_distance_top.sv
`timescale 1ns / 1ps
// Bounded case-insensitive edit distance: a systolic row of 17 DP cells.
// Throughput: one item per cycle outside init, result register free; the row stalls as a whole.
// Result path: an end-of-word item passes the token registers of the head and cells 1..p-1,
// then the distance in cell p is captured, p = pattern length in use (at acceptance if p = 0).
// Reset: asynchronous, active low; the row is initialized in the first cycle after reset
// and in the cycle after every register write, with s_tready low during that cycle.
module bounded_edit_distance_top
	import bed_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input items
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] character
	input  logic             s_tuser,   // [0] kind: 0 character, 1 end of word
	// results
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [3:0] distance, [4] is_match, [7:5] zero
	// configuration writes
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// configuration registers
	logic [CFG_W-1:0]  pat_lo_q;
	logic [CFG_W-1:0]  pat_hi_q;
	logic [LEN_W-1:0]  plen_q;
	logic [MAXD_W-1:0] maxd_q;
	logic              init_q;

	logic [DIST_W-1:0] lim;
	logic [LEN_W-1:0]  plen_used;
	logic [2*CFG_W-1:0] pat_all;

	// row state: index 0 is the head (column zero), 1..MAX_PATTERN the pattern cells
	tok_t              cell_tok  [MAX_PATTERN+1];
	logic [DIST_W-1:0] cell_cur  [MAX_PATTERN+1];
	logic [DIST_W-1:0] cell_prev [MAX_PATTERN+1];

	// pos_tok[k]: item about to enter cell k (k = 0: the input item itself)
	tok_t              pos_tok   [MAX_PATTERN+1];
	tok_t              in_tok;

	logic              adv;
	logic              m_valid_q;
	logic [DIST_W-1:0] dist_q;
	logic              match_q;
	tok_t              tap_tok;
	logic [DIST_W-1:0] tap_val;

	assign lim       = {1'b0, maxd_q} + DIST_W'(1);
	assign plen_used = (plen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_q;
	assign pat_all   = {pat_hi_q, pat_lo_q};

	// the row moves only when the result register can take a result
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = adv && !init_q;

	assign in_tok.vld = s_tvalid && s_tready;
	assign in_tok.eow = s_tuser;
	assign in_tok.ch  = fold_case(s_tdata);

	// configuration: any write reinitializes the row in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			plen_q   <= '0;
			maxd_q   <= MAXD_W'(2);
			init_q   <= 1'b1;
		end else begin
			init_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_PAT_LO:   pat_lo_q <= cfg_data;
					REG_PAT_HI:   pat_hi_q <= cfg_data;
					REG_PAT_LEN:  plen_q   <= cfg_data[LEN_W-1:0];
					REG_MAX_DIST: maxd_q   <= cfg_data[MAXD_W-1:0];
					default: ;
				endcase
			end
		end
	end

	bed_head u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.init   (init_q),
		.lim    (lim),
		.in_tok (in_tok),
		.tok    (cell_tok[0]),
		.cur    (cell_cur[0]),
		.prev   (cell_prev[0])
	);

	assign pos_tok[0] = in_tok;

	for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
		assign pos_tok[j] = cell_tok[j-1];

		bed_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.init       (init_q),
			.init_value (init_val(j, lim)),
			.lim        (lim),
			.pat_ch     (fold_case(pat_all[CHAR_W*(j-1) +: CHAR_W])),
			.left_tok   (cell_tok[j-1]),
			.left_cur   (cell_cur[j-1]),
			.left_prev  (cell_prev[j-1]),
			.tok        (cell_tok[j]),
			.cur        (cell_cur[j]),
			.prev       (cell_prev[j])
		);
	end

	// an end-of-word item about to enter cell p finds the final distance in cell p
	assign tap_tok = pos_tok[plen_used];
	assign tap_val = cell_cur[plen_used];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && tap_tok.vld && tap_tok.eow) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tap_tok.vld && tap_tok.eow) begin
			dist_q  <= tap_val;
			match_q <= (tap_val != lim);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, match_q, dist_q};

`ifndef SYNTH
	// a reported distance never exceeds the limit
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] <= lim))
		else $error("distance above limit");

	// match flag agrees with the distance and the current threshold
	a_match_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4] == (m_tdata[3:0] <= {1'b0, maxd_q})))
		else $error("match flag inconsistent with distance");

	// no item is taken while the row is being initialized
	a_init_block: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !s_tready)
		else $error("input accepted during row init");

	// once an end of word has swept the whole row, the last cell holds its reset value
	a_sweep_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_tok[MAX_PATTERN].vld && cell_tok[MAX_PATTERN].eow)
		|-> (cell_cur[MAX_PATTERN] == lim))
		else $error("last cell not reinitialized after end of word");
`endif

endmodule
